// ===== rtl/rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// rtp_pkg
// shared types, constants and codes of the reference-counted token pool
// ----------------------------------------------------------------------------
package rtp_pkg;

	localparam int POOL_SIZE = 1024;
	localparam int IDX_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	// stream widths
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 32;
	localparam int OUT_TUSER_W = 1;
	localparam int TOKEN_W     = 10;
	localparam int COUNT_W     = 11;

	// item kinds and result codes
	localparam logic MODE_ADD     = 1'b0;
	localparam logic MODE_REL     = 1'b1;
	localparam logic STAT_DONE    = 1'b0;
	localparam logic STAT_EMPTY   = 1'b1;

	typedef struct packed {
		logic             some;
		logic [IDX_W-1:0] idx;
	} rtp_link_t;

	typedef struct packed {
		rtp_link_t        link;
		logic [CNT_W-1:0] usage;
	} rtp_word_t;

	localparam int WORD_W = $bits(rtp_word_t);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD_HEAD,
		S_ADD_PRED,
		S_ADD_INC,
		S_ADD_NEW,
		S_REL_RD,
		S_REL_EXEC,
		S_DONE
	} rtp_state_t;

	typedef enum logic [1:0] {
		RD_HEAD,
		RD_IDX,
		RD_CUR
	} rtp_rdsel_t;

	typedef struct packed {
		logic       clr_step;
		logic       take;
		rtp_rdsel_t rd_sel;
		logic       cap_link;
		logic       add_inc;
		logic       add_new;
		logic       rel_step;
		logic       load_out;
	} rtp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic empty;
		logic walk_more;
		logic out_free;
	} rtp_stat_t;

endpackage

// ===== rtl/rtp_ram.sv =====
// ----------------------------------------------------------------------------
// rtp_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rtp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/rtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtp_ctrl
// sequencer for clearing pass, add and release walk
// ----------------------------------------------------------------------------
module rtp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_mode,
	input  logic                in_has,
	input  rtp_pkg::rtp_stat_t  stat,
	output logic                in_ready,
	output rtp_pkg::rtp_cmd_t   cmd,
	output rtp_pkg::rtp_state_t state
);
	import rtp_pkg::*;

	rtp_state_t state_q;
	rtp_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (in_mode == MODE_ADD) begin
						state_d = stat.empty ? S_DONE : S_ADD_HEAD;
					end else begin
						state_d = in_has ? S_REL_RD : S_DONE;
					end
				end
			end
			S_ADD_HEAD: state_d = S_ADD_PRED;
			S_ADD_PRED: state_d = S_ADD_INC;
			S_ADD_INC:  state_d = S_ADD_NEW;
			S_ADD_NEW:  state_d = S_DONE;
			S_REL_RD:   state_d = S_REL_EXEC;
			S_REL_EXEC: state_d = stat.walk_more ? S_REL_RD : S_DONE;
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default:    state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_CUR;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_ADD_HEAD: cmd.rd_sel = RD_HEAD;
			S_ADD_PRED: begin
				cmd.rd_sel   = RD_IDX;
				cmd.cap_link = 1'b1;
			end
			S_ADD_INC:  cmd.add_inc  = 1'b1;
			S_ADD_NEW:  cmd.add_new  = 1'b1;
			S_REL_RD:   cmd.rd_sel   = RD_CUR;
			S_REL_EXEC: cmd.rel_step = 1'b1;
			S_DONE:     cmd.load_out = stat.out_free;
			default:    cmd = '0;
		endcase
	end

	assign state = state_q;

endmodule

// ===== rtl/rtp_dpath.sv =====
// ----------------------------------------------------------------------------
// rtp_dpath
// slot memory, free-list head and count, walk registers and result register
// ----------------------------------------------------------------------------
module rtp_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rtp_pkg::rtp_cmd_t             cmd,
	input  logic                          in_mode,
	input  logic                          in_has,
	input  logic [rtp_pkg::IDX_W-1:0]     in_idx,
	input  logic                          out_ready,
	output rtp_pkg::rtp_stat_t            stat,
	output logic                          out_valid,
	output logic                          out_status,
	output logic [rtp_pkg::TOKEN_W-1:0]   out_new_index,
	output logic [rtp_pkg::COUNT_W-1:0]   out_freed,
	output logic [rtp_pkg::COUNT_W-1:0]   out_free_slots
);
	import rtp_pkg::*;

	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_POOL = CNT_W'(POOL_SIZE);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(POOL_SIZE - 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_SIZE - 1);

	// control state
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] total_q;
	logic             out_valid_q;

	// item and walk registers
	logic             mode_q;
	logic             has_q;
	logic             refused_q;
	logic             pred_ok_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cur_q;
	logic [IDX_W-1:0] slot_q;
	rtp_link_t        head_link_q;
	logic [CNT_W-1:0] freed_q;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	rtp_word_t        ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	rtp_word_t        rd_w;
	logic             pred_live;
	logic             hits_zero;

	rtp_ram #(
		.WIDTH (WORD_W),
		.DEPTH (POOL_SIZE)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_w      = ram_rdata;
	assign pred_live = has_q && (rd_w.usage != '0);
	assign hits_zero = (rd_w.usage == CNT_ONE);

	always_comb begin
		case (cmd.rd_sel)
			RD_HEAD: ram_raddr = head_q;
			RD_IDX:  ram_raddr = idx_q;
			RD_CUR:  ram_raddr = cur_q;
			default: ram_raddr = cur_q;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = '0;
		if (cmd.clr_step) begin
			// initial free list runs from the top slot down to slot 0
			ram_we              = 1'b1;
			ram_waddr           = clr_q;
			ram_wdata.link.some = (clr_q != '0);
			ram_wdata.link.idx  = clr_q - IDX_W'(1);
		end else if (cmd.add_inc) begin
			if (pred_live && (rd_w.usage < CNT_POOL)) begin
				ram_we          = 1'b1;
				ram_waddr       = idx_q;
				ram_wdata.link  = rd_w.link;
				ram_wdata.usage = rd_w.usage + CNT_ONE;
			end
		end else if (cmd.add_new) begin
			ram_we              = 1'b1;
			ram_waddr           = slot_q;
			ram_wdata.link.some = pred_ok_q;
			ram_wdata.link.idx  = pred_ok_q ? idx_q : '0;
			ram_wdata.usage     = CNT_ONE;
		end else if (cmd.rel_step) begin
			if (rd_w.usage != '0) begin
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				if (hits_zero) begin
					// slot goes on top of the free list
					ram_wdata.link.some = (total_q != '0);
					ram_wdata.link.idx  = (total_q != '0) ? head_q : '0;
					ram_wdata.usage     = '0;
				end else begin
					ram_wdata.link  = rd_w.link;
					ram_wdata.usage = rd_w.usage - CNT_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			head_q      <= IDX_LAST;
			total_q     <= CNT_POOL;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.add_inc) begin
				total_q <= total_q - CNT_ONE;
				if (head_link_q.some) head_q <= head_link_q.idx;
			end else if (cmd.rel_step && hits_zero) begin
				total_q <= total_q + CNT_ONE;
				head_q  <= cur_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q    <= in_mode;
			has_q     <= in_has;
			idx_q     <= in_idx;
			cur_q     <= in_idx;
			slot_q    <= head_q;
			freed_q   <= '0;
			refused_q <= (in_mode == MODE_ADD) && (total_q == '0);
		end
		if (cmd.cap_link) begin
			head_link_q <= rd_w.link;
		end
		if (cmd.add_inc) begin
			pred_ok_q <= pred_live;
		end
		if (cmd.rel_step && hits_zero) begin
			freed_q <= freed_q + CNT_ONE;
			cur_q   <= rd_w.link.idx;
		end
		if (cmd.load_out) begin
			out_status     <= refused_q ? STAT_EMPTY : STAT_DONE;
			out_new_index  <= ((mode_q == MODE_ADD) && !refused_q) ?
				TOKEN_W'(slot_q) : '0;
			out_freed      <= COUNT_W'(freed_q);
			out_free_slots <= refused_q ? '0 : COUNT_W'(total_q);
		end
	end

	assign stat.clr_last  = (clr_q == IDX_LAST);
	assign stat.empty     = (total_q == '0);
	assign stat.walk_more = hits_zero && rd_w.link.some && (freed_q < CNT_LAST);
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;

endmodule

// ===== rtl/refcounted_token_pool_top.sv =====
// ----------------------------------------------------------------------------
// refcounted_token_pool_top
// reference-counted token pool with a free list and predecessor chains
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request beat: tuser picks add or release, tdata names
//   the slot (predecessor for add, target for release). m_axis returns one
//   result beat per request: status in tuser, indices and counts in tdata.
// steps from accept to result (one item in flight at a time):
//   add                 head read, predecessor read, one or two writes
//   add on empty pool   straight to the result
//   release             one read then one write of the slot ram for each
//                       slot visited on the chain walk
//   release of no slot  straight to the result
//   s_axis_tready comes back in the same cycle as the result beat.
// a finished beat sits in the output register, so the next request is
// accepted while m_axis is stalled; the block only waits in its last step
// when the output register still holds an untaken beat.
// reset: a clearing pass writes the initial free list into each slot of
// the slot ram; s_axis_tready stays low until it is over.
// ----------------------------------------------------------------------------
module refcounted_token_pool_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// token_index[9:0], zero pad
	input  logic [rtp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// mode[0], has_token[1]
	input  logic [rtp_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// new_index[9:0], freed_count[20:10], free_slots[31:21]
	output logic [rtp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// status[0]
	output logic [rtp_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
	import rtp_pkg::*;

	rtp_cmd_t   cmd;
	rtp_stat_t  stat;
	rtp_state_t state;

	logic               out_status;
	logic [TOKEN_W-1:0] out_new_index;
	logic [COUNT_W-1:0] out_freed;
	logic [COUNT_W-1:0] out_free_slots;

	// sequencer
	rtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser[0]),
		.in_has   (s_axis_tuser[1]),
		.stat     (stat),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.state    (state)
	);

	// slot ram, free list and result register
	rtp_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_mode        (s_axis_tuser[0]),
		.in_has         (s_axis_tuser[1]),
		.in_idx         (s_axis_tdata[IDX_W-1:0]),
		.out_ready      (m_axis_tready),
		.stat           (stat),
		.out_valid      (m_axis_tvalid),
		.out_status     (out_status),
		.out_new_index  (out_new_index),
		.out_freed      (out_freed),
		.out_free_slots (out_free_slots)
	);

	// pack result beat, lowest field first, fields fill all 32 bits
	assign m_axis_tdata = {out_free_slots, out_freed, out_new_index};
	assign m_axis_tuser = out_status;

	// one request in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request accepted while previous one still in work");

	// no request taken during the clearing pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_CLEAR) |-> !s_axis_tready)
		else $error("ready high during clearing pass");

	// refused add reports no slot and no free count
	a_refused_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser[0] == STAT_EMPTY)) |->
		((m_axis_tdata[9:0] == '0) && (m_axis_tdata[31:21] == '0)))
		else $error("refused add carries slot or free count");

	// free count never exceeds the pool
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:21] <= COUNT_W'(POOL_SIZE)))
		else $error("free count above pool size");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the reference-counted token pool: a directed table
// and random add/release traffic with short chains under changing stall
// patterns on both streams. every accepted request is run through a local
// model of the slot store, and each result beat is checked field by field in
// order against it, or against the row's want where a directed row is typed.
// ----------------------------------------------------------------------------
module tb_top;
	import rtp_pkg::*;

	// generous bound, far above the slowest expected item mix
	localparam int CYCLE_LIMIT = 600000;
	localparam int DIR_ROWS_N  = 16;
	localparam int RAND_OPS    = 684;
	localparam int TAIL_WAIT   = 64;

	typedef struct packed {
		logic               status;
		logic [TOKEN_W-1:0] new_index;
		logic [COUNT_W-1:0] freed_count;
		logic [COUNT_W-1:0] free_slots;
	} token_outcome_t;

	// one directed request; want is used only when typed is set
	typedef struct packed {
		logic               mode;
		logic               has;
		logic [TOKEN_W-1:0] idx;
		bit                 typed;
		token_outcome_t     want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
		// after reset the head is the top slot, free list counts down
		'{MODE_ADD, 1'b0, 10'd0,    1'b1, '{STAT_DONE, 10'd1023, 11'd0, 11'd1023}},
		'{MODE_ADD, 1'b1, 10'd1023, 1'b1, '{STAT_DONE, 10'd1022, 11'd0, 11'd1022}},
		'{MODE_ADD, 1'b1, 10'd1022, 1'b1, '{STAT_DONE, 10'd1021, 11'd0, 11'd1021}},
		// drop the own references, chain stays held by successors
		'{MODE_REL, 1'b1, 10'd1023, 1'b0, '0},
		'{MODE_REL, 1'b1, 10'd1022, 1'b0, '0},
		// releasing the tail walks the whole chain back to the free list
		'{MODE_REL, 1'b1, 10'd1021, 1'b1, '{STAT_DONE, 10'd0, 11'd3, 11'd1024}},
		// release of a free slot and release with no slot do nothing
		'{MODE_REL, 1'b1, 10'd1023, 1'b1, '{STAT_DONE, 10'd0, 11'd0, 11'd1024}},
		'{MODE_REL, 1'b0, 10'd0,    1'b1, '{STAT_DONE, 10'd0, 11'd0, 11'd1024}},
		// predecessor not allocated: counts as none; the next add links to the new slot
		'{MODE_ADD, 1'b1, 10'd5,    1'b0, '0},
		'{MODE_ADD, 1'b1, 10'd1023, 1'b0, '0},
		// count above one: decrement only, no walk; then a release with has_token low
		'{MODE_REL, 1'b1, 10'd1023, 1'b0, '0},
		'{MODE_REL, 1'b0, 10'd1022, 1'b0, '0},
		// index given but has_token low: no predecessor
		'{MODE_ADD, 1'b0, 10'd1022, 1'b0, '0},
		'{MODE_REL, 1'b1, 10'd1022, 1'b0, '0},
		'{MODE_REL, 1'b1, 10'd1021, 1'b0, '0},
		// count already zero
		'{MODE_REL, 1'b1, 10'd1021, 1'b0, '0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;
	logic [IN_TUSER_W-1:0]   s_axis_tuser;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic [OUT_TUSER_W-1:0]  m_axis_tuser;

	// local copy of the slot store
	logic               link_on  [POOL_SIZE];
	logic [TOKEN_W-1:0] link_to  [POOL_SIZE];
	logic [COUNT_W-1:0] usage    [POOL_SIZE];
	bit                 live     [POOL_SIZE];
	int                 free_head;
	int                 free_total;

	token_outcome_t owed_outcomes [$];

	int src_idle_pct;
	int sink_idle_pct;
	int cycle_count;
	int mismatches;
	int results_seen;
	int requests_sent;
	int effective_ops;
	int refused_adds;
	int longest_walk;
	logic [TOKEN_W-1:0] last_new;

	refcounted_token_pool_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// model of one request: updates the slot store and returns the result
	function automatic token_outcome_t apply_token_op(logic mode, logic has,
			logic [TOKEN_W-1:0] idx);
		token_outcome_t r;
		bit             pred;
		int             s;
		int             cur;
		int             steps;
		logic           nxt_on;
		logic [TOKEN_W-1:0] nxt_to;
		r = '0;
		if (mode == MODE_ADD) begin
			if (free_total == 0) begin
				// full pool: refused, nothing changes
				r.status = STAT_EMPTY;
			end else begin
				pred = has && live[idx];
				s = free_head;
				if (pred && usage[idx] < POOL_SIZE)
					usage[idx] = usage[idx] + 1'b1;
				free_total--;
				if (link_on[s])
					free_head = link_to[s];
				usage[s]   = COUNT_W'(1);
				live[s]    = 1'b1;
				link_on[s] = pred;
				link_to[s] = pred ? idx : '0;
				r.new_index = TOKEN_W'(s);
			end
		end else if (has && live[idx]) begin
			cur = idx;
			steps = 0;
			while (1) begin
				if (usage[cur] == 0)
					break;
				usage[cur] = usage[cur] - 1'b1;
				if (usage[cur] != 0)
					break;
				nxt_on = link_on[cur];
				nxt_to = link_to[cur];
				// push the slot on the free list
				link_on[cur] = (free_total > 0);
				link_to[cur] = TOKEN_W'(free_head);
				free_head    = cur;
				live[cur]    = 1'b0;
				free_total++;
				r.freed_count = r.freed_count + 1'b1;
				steps++;
				if (steps >= POOL_SIZE || !nxt_on)
					break;
				cur = nxt_to;
				if (!live[cur])
					break;
			end
		end
		r.free_slots = (r.status != STAT_DONE) ? '0 : free_total[COUNT_W-1:0];
		return r;
	endfunction

	// any allocated slot, searched from a random start; -1 if none
	function automatic int pick_live();
		int start;
		int j;
		start = $urandom_range(POOL_SIZE - 1);
		for (int i = 0; i < POOL_SIZE; i++) begin
			j = (start + i) % POOL_SIZE;
			if (live[j])
				return j;
		end
		return -1;
	endfunction

	task automatic report_mismatch(string field, int got, int exp);
		$display("mismatch in %s at result %0d: got %0d, expected %0d",
			field, results_seen, got, exp);
		mismatches++;
	endtask

	// one request beat; the expectation is queued at the accepting edge
	task automatic send_op(logic mode, logic has, logic [TOKEN_W-1:0] idx,
			bit typed = 1'b0, token_outcome_t want = '0);
		token_outcome_t r;
		bit             counts;
		counts = (mode == MODE_ADD) || (has && live[idx]);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - TOKEN_W){1'b0}}, idx};
		s_axis_tuser  <= {has, mode};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = apply_token_op(mode, has, idx);
		owed_outcomes.push_back(typed ? want : r);
		last_new = r.new_index;
		requests_sent++;
		if (counts)
			effective_ops++;
		if (r.status == STAT_EMPTY)
			refused_adds++;
		if (r.freed_count > longest_walk)
			longest_walk = r.freed_count;
		// random gap after the beat, valid stays up when there is none
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
	endtask

	// hold off new requests until every result is back
	task automatic wait_results_home();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// add with a predecessor, then drop the predecessor's own reference,
	// so the chain is held only through its tail
	task automatic grow_chain(int len, bit free_tail);
		logic [TOKEN_W-1:0] tail_slot;
		logic [TOKEN_W-1:0] fresh;
		send_op(MODE_ADD, 1'b0, TOKEN_W'($urandom));
		tail_slot = last_new;
		for (int k = 0; k < len; k++) begin
			send_op(MODE_ADD, 1'b1, tail_slot);
			fresh = last_new;
			send_op(MODE_REL, 1'b1, tail_slot);
			tail_slot = fresh;
		end
		if (free_tail)
			send_op(MODE_REL, 1'b1, tail_slot);
	endtask

	// mostly well-formed traffic on allocated slots, some noise
	task automatic random_traffic(int n);
		int target;
		int sel;
		int slot;
		target = requests_sent + n;
		while (requests_sent < target) begin
			sel  = $urandom_range(99);
			slot = pick_live();
			// keep plenty of room in the pool
			if (free_total < 256 && slot >= 0)
				sel = 50;
			if (sel < 35) begin
				if (slot >= 0)
					send_op(MODE_ADD, 1'b1, TOKEN_W'(slot));
				else
					send_op(MODE_ADD, 1'b0, TOKEN_W'($urandom));
			end else if (sel < 45) begin
				send_op(MODE_ADD, 1'($urandom), TOKEN_W'($urandom));
			end else if (sel < 75) begin
				if (slot >= 0)
					send_op(MODE_REL, 1'b1, TOKEN_W'(slot));
				else
					send_op(MODE_REL, 1'($urandom), TOKEN_W'($urandom));
			end else if (sel < 90) begin
				grow_chain($urandom_range(1, 5), 1'($urandom));
			end else begin
				send_op(MODE_REL, 1'($urandom), TOKEN_W'($urandom));
			end
		end
	endtask

	// result side: random stalls, in-order check against the model
	always @(posedge clk) begin
		token_outcome_t seen;
		token_outcome_t want;
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.status      = m_axis_tuser[0];
			seen.new_index   = m_axis_tdata[TOKEN_W-1:0];
			seen.freed_count = m_axis_tdata[TOKEN_W +: COUNT_W];
			seen.free_slots  = m_axis_tdata[TOKEN_W + COUNT_W +: COUNT_W];
			if (owed_outcomes.size() == 0) begin
				report_mismatch("unexpected beat", m_axis_tdata, 0);
			end else begin
				want = owed_outcomes.pop_front();
				if (seen.status !== want.status)
					report_mismatch("status", seen.status, want.status);
				if (seen.new_index !== want.new_index)
					report_mismatch("new_index", seen.new_index, want.new_index);
				if (seen.freed_count !== want.freed_count)
					report_mismatch("freed_count", seen.freed_count, want.freed_count);
				if (seen.free_slots !== want.free_slots)
					report_mismatch("free_slots", seen.free_slots, want.free_slots);
			end
			results_seen++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycle_count, owed_outcomes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		arst_n        = 1'b0;
		cycle_count   = 0;
		mismatches    = 0;
		results_seen  = 0;
		requests_sent = 0;
		effective_ops = 0;
		refused_adds  = 0;
		longest_walk  = 0;
		last_new      = '0;
		src_idle_pct  = 36;
		sink_idle_pct = 65;

		// model reset: slot i links to i-1, everything free
		for (int i = 0; i < POOL_SIZE; i++) begin
			link_on[i] = (i != 0);
			link_to[i] = TOKEN_W'(i - 1);
			usage[i]   = '0;
			live[i]    = 1'b0;
		end
		free_head  = POOL_SIZE - 1;
		free_total = POOL_SIZE;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, the block's clearing pass holds tready low first
		for (int i = 0; i < DIR_ROWS_N; i++)
			send_op(DIR_ROWS[i].mode, DIR_ROWS[i].has, DIR_ROWS[i].idx,
				DIR_ROWS[i].typed, DIR_ROWS[i].want);
		wait_results_home();

		// sender light, receiver heavy stalls
		random_traffic(RAND_OPS / 3);
		wait_results_home();

		// the other way round
		src_idle_pct  = 65;
		sink_idle_pct = 36;
		random_traffic(RAND_OPS / 3);
		wait_results_home();

		// full rate on both sides
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		random_traffic(RAND_OPS - 2 * (RAND_OPS / 3));
		wait_results_home();

		// no stray beat may follow the last result
		repeat (TAIL_WAIT) @(posedge clk);

		$display("ran %0d requests (%0d on live state, %0d adds refused), checked %0d results",
			requests_sent, effective_ops, refused_adds, results_seen);
		$display("longest release walk freed %0d slots, %0d mismatches",
			longest_walk, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
